@@ rtl/triangle_gradient_pixel_shader_top_defines.svh @@
// Assertion macros for the triangle gradient pixel shader.
// Included by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef TRIANGLE_GRADIENT_PIXEL_SHADER_TOP_DEFINES_SVH
`define TRIANGLE_GRADIENT_PIXEL_SHADER_TOP_DEFINES_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define TGPS_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define TGPS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

// Condition implies a consequence a fixed number of cycles later.
`define TGPS_ASSERT_DELAY(label, cond, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/tgps_pkg.sv @@
// Shared constants, types and helpers of the triangle gradient pixel shader.
// No dependencies; used by every module of the block.
package tgps_pkg;

  // Fixed-point constants of the triangle geometry.
  localparam longint WidthNum  = 11547005;
  localparam longint HeightNum = 8660254;
  localparam longint ScaleDen  = 10000000;
  localparam longint SpanDen   = 20000000;
  localparam int     ColorOne  = 'h100;
  localparam int     MaxDim    = 4096;

  // Reciprocals for division by constants, scaled by 2^RecipShift.
  localparam int RecipShift = 16;
  localparam int RecipW     = 17;
  localparam logic [RecipW-1:0] WidthRecip  = RecipW'((WidthNum << RecipShift) / ScaleDen);
  localparam logic [RecipW-1:0] HeightRecip = RecipW'((HeightNum << RecipShift) / ScaleDen);
  localparam logic [RecipW-1:0] SpanRecip   = RecipW'((WidthNum << RecipShift) / SpanDen);

  // Datapath widths.
  localparam int DimW     = 13;               // screen and triangle dimensions
  localparam int CoordW   = 12;               // pixel coordinates
  localparam int SqW      = 2 * DimW;         // squared distance
  localparam int RemW     = SqW + 1;          // square root working register
  localparam int RootW    = DimW;             // square root result bits, one cell each
  localparam int ColW     = 8;
  localparam int DivSteps = ColW + 1;         // quotient bits, one cell each
  localparam int NumW     = DimW + ColW;      // dividend of the colour division
  localparam int NumChan  = 3;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // Triangle geometry derived from the screen size.
  typedef struct packed {
    logic            ok;
    logic [DimW-1:0] tw;
    logic [DimW-1:0] x1;
    logic [DimW-1:0] x2;
    logic [DimW-1:0] x3;
    logic [DimW-1:0] y1;
    logic [DimW-1:0] y2;
  } geom_t;

  // Control tag that travels beside the datapath.
  typedef struct packed {
    logic vld;
    logic ins;
  } tag_t;

  // Magnitude of a small signed difference.
  function automatic logic [DimW-1:0] abs_diff(input logic signed [DimW+1:0] a);
    logic signed [DimW+1:0] m;
    m = (a < 0) ? -a : a;
    return m[DimW-1:0];
  endfunction

endpackage

@@ rtl/tgps_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per cycle.
// Depends on tgps_pkg.
module tgps_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic [tgps_pkg::SqW-1:0]  v_in,
  input  logic [tgps_pkg::RemW-1:0] r_in,
  output logic [tgps_pkg::SqW-1:0]  v_out,
  output logic [tgps_pkg::RemW-1:0] r_out
);
  import tgps_pkg::*;

  localparam logic [RemW-1:0] Bit = RemW'(1) << (2 * STEP);

  logic [RemW-1:0] trial;
  logic            take;

  // Trial subtraction of the current root plus this cell's bit.
  assign trial = r_in + Bit;
  assign take  = RemW'(v_in) >= trial;

  always_ff @(posedge clk) begin
    if (take) begin
      v_out <= SqW'(RemW'(v_in) - trial);
      r_out <= (r_in >> 1) + Bit;
    end else begin
      v_out <= v_in;
      r_out <= r_in >> 1;
    end
  end

endmodule

@@ rtl/tgps_div_cell.sv @@
// One cell of the colour divider chain: resolves one quotient bit per cycle.
// Depends on tgps_pkg.
module tgps_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic [tgps_pkg::DimW-1:0]     den,
  input  logic [tgps_pkg::NumW-1:0]     rem_in,
  input  logic [tgps_pkg::DivSteps-1:0] q_in,
  output logic [tgps_pkg::NumW-1:0]     rem_out,
  output logic [tgps_pkg::DivSteps-1:0] q_out
);
  import tgps_pkg::*;

  localparam logic [DivSteps-1:0] QBit = DivSteps'(1) << SHIFT;

  logic [NumW-1:0] den_sh;

  // Divisor aligned to this cell's quotient bit.
  assign den_sh = NumW'(den) << SHIFT;

  always_ff @(posedge clk) begin
    if (rem_in >= den_sh) begin
      rem_out <= rem_in - den_sh;
      q_out   <= q_in | QBit;
    end else begin
      rem_out <= rem_in;
      q_out   <= q_in;
    end
  end

endmodule

@@ rtl/tgps_geom.sv @@
// Triangle geometry from the configured screen size, in three register stages.
// Depends on tgps_pkg.
module tgps_geom (
  input  logic                      clk,
  input  logic [tgps_pkg::DimW-1:0] screen_width,
  input  logic [tgps_pkg::DimW-1:0] screen_height,
  output tgps_pkg::geom_t           geom
);
  import tgps_pkg::*;

  localparam int ProdW = DimW + 24;
  localparam int RecW  = DimW + RecipW;

  logic [DimW-1:0]  sw, sh;
  logic [DimW-1:0]  sw1, sh1, qw1, qh1;
  logic [ProdW-1:0] pw1, ph1;
  logic [DimW-1:0]  sw2, sh2, tw2, th2;
  logic [DimW-1:0]  tw, th, x1, x3, y2;
  logic [DimW:0]    xsum;

  // Saturate the screen size to the largest supported dimension.
  assign sw = (32'(screen_width) > MaxDim) ? DimW'(MaxDim) : screen_width;
  assign sh = (32'(screen_height) > MaxDim) ? DimW'(MaxDim) : screen_height;

  // Stage one: exact products and reciprocal estimates of the quotients.
  always_ff @(posedge clk) begin
    sw1 <= sw;
    sh1 <= sh;
    pw1 <= ProdW'(sh) * ProdW'(WidthNum);
    ph1 <= ProdW'(sw) * ProdW'(HeightNum);
    qw1 <= DimW'((RecW'(sh) * RecW'(WidthRecip)) >> RecipShift);
    qh1 <= DimW'((RecW'(sw) * RecW'(HeightRecip)) >> RecipShift);
  end

  // Stage two: the estimate is at most one low, so one compare corrects it.
  always_ff @(posedge clk) begin
    sw2 <= sw1;
    sh2 <= sh1;
    tw2 <= qw1 + DimW'((ProdW'(qw1) + ProdW'(1)) * ProdW'(ScaleDen) <= pw1);
    th2 <= qh1 + DimW'((ProdW'(qh1) + ProdW'(1)) * ProdW'(ScaleDen) <= ph1);
  end

  // Stage three: clamp to the screen and place the corners.
  assign tw   = (tw2 > sw2) ? sw2 : tw2;
  assign th   = (th2 > sh2) ? sh2 : th2;
  assign x1   = (sw2 - tw) >> 1;
  assign x3   = x1 + tw - DimW'(1);
  assign xsum = (DimW+1)'(x1) + (DimW+1)'(x3);
  assign y2   = (sh2 - th) >> 1;

  always_ff @(posedge clk) begin
    geom.ok <= (tw != '0) && (th != '0);
    geom.tw <= tw;
    geom.x1 <= x1;
    geom.x2 <= xsum[DimW:1];
    geom.x3 <= x3;
    geom.y2 <= y2;
    geom.y1 <= y2 + th - DimW'(1);
  end

endmodule

@@ rtl/triangle_gradient_pixel_shader_top.sv @@
// Top level of the triangle gradient pixel shader.
// Depends on tgps_pkg, tgps_geom, tgps_sqrt_cell, tgps_div_cell and the defines header.
//
// Usage:
// A pixel is handed over by raising start with pixel_x and pixel_y; the
// transaction is taken at a clock edge where start is high and busy is low.
// The result (inside_res, red, green, blue) appears for one cycle with done
// high, from the output register. The datapath is a row of cells:
// an input register, five set-up stages, thirteen square root cells (one
// root bit each), one dividend stage, nine divider cells (one quotient bit
// each) and the output register, so a new pixel may be taken every cycle.
// The receiver cannot stall: every result is shown exactly once.
// Screen size is written over the cfg channel (index 0 width, 1 height),
// always ready. After a write or reset, busy is high while the triangle
// geometry is recomputed. Reset restores 640 by 480 and empties the
// pipeline.
`include "triangle_gradient_pixel_shader_top_defines.svh"

module triangle_gradient_pixel_shader_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tgps_pkg::CoordW-1:0] pixel_x,
  input  logic [tgps_pkg::CoordW-1:0] pixel_y,
  output logic                        done,
  output logic                        inside_res,
  output logic [tgps_pkg::ColW-1:0]   red,
  output logic [tgps_pkg::ColW-1:0]   green,
  output logic [tgps_pkg::ColW-1:0]   blue,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  tgps_pkg::cfg_reg_t          cfg_index,
  input  logic [tgps_pkg::DimW-1:0]   cfg_data
);
  import tgps_pkg::*;

  localparam int SpanW  = CoordW + 25;
  localparam int SRecW  = CoordW + RecipW;
  localparam int TagLen = RootW + 1 + DivSteps;
  localparam int Lat    = 6 + TagLen + 1;
  localparam logic [1:0] SettleCycles = 2'd3;

  logic [DimW-1:0] screen_width, screen_height;
  logic [1:0]      settle;
  geom_t           geom;

  logic                  v_s0, v_s1, v_s2, v_s3, v_s4, v_s5;
  logic                  iny_s1, iny_s2, ins_s3, ins_s4, ins_s5;
  logic [CoordW-1:0]     px_s0, py_s0, px_s1, py_s1, px_s2, py_s2;
  logic [CoordW-1:0]     lq_s1, lw_s2;
  logic [SpanW-1:0]      lp_s1;
  logic [CoordW-1:0]     ky;
  logic signed [DimW+1:0] xs, ys, left_edge, right_edge;
  logic signed [DimW+1:0] gx1, gx2, gx3, gy1, gy2;
  logic                  in_span;
  logic [DimW-1:0]       dx [NumChan], dy [NumChan];
  logic [DimW-1:0]       dx_s3 [NumChan], dy_s3 [NumChan];
  logic [SqW-1:0]        sqx_s4 [NumChan], sqy_s4 [NumChan], sum_s5 [NumChan];
  logic [SqW-1:0]        sv [NumChan][RootW+1];
  logic [RemW-1:0]       sr [NumChan][RootW+1];
  logic [NumW-1:0]       dr [NumChan][DivSteps+1];
  logic [DivSteps-1:0]   dq [NumChan][DivSteps+1];
  logic [RootW-1:0]      root [NumChan];
  tag_t                  tag_line [TagLen];

  // Configuration registers and geometry settle counter.
  assign cfg_ready = 1'b1;
  assign busy      = (settle != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DimW'(640);
      screen_height <= DimW'(480);
      settle        <= SettleCycles;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
      settle <= SettleCycles;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  tgps_geom u_geom (
    .clk           (clk),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .geom          (geom)
  );

  // Valid bits of the set-up stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
      v_s3 <= 1'b0;
      v_s4 <= 1'b0;
      v_s5 <= 1'b0;
    end else begin
      v_s0 <= start && !busy;
      v_s1 <= v_s0;
      v_s2 <= v_s1;
      v_s3 <= v_s2;
      v_s4 <= v_s3;
      v_s5 <= v_s4;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    px_s0 <= pixel_x;
    py_s0 <= pixel_y;
  end

  // Stage one: row test and the half span estimate.
  assign ky = CoordW'(DimW'(py_s0) - geom.y2);

  always_ff @(posedge clk) begin
    px_s1  <= px_s0;
    py_s1  <= py_s0;
    iny_s1 <= geom.ok && (DimW'(py_s0) >= geom.y2) && (DimW'(py_s0) <= geom.y1);
    lp_s1  <= SpanW'(ky) * SpanW'(WidthNum);
    lq_s1  <= CoordW'((SRecW'(ky) * SRecW'(SpanRecip)) >> RecipShift);
  end

  // Stage two: correct the half span by one where the estimate fell short.
  always_ff @(posedge clk) begin
    px_s2  <= px_s1;
    py_s2  <= py_s1;
    iny_s2 <= iny_s1;
    lw_s2  <= lq_s1 + CoordW'((SpanW'(lq_s1) + SpanW'(1)) * SpanW'(SpanDen) <= lp_s1);
  end

  // Stage three: column test and corner distances, in signed arithmetic.
  assign xs         = $signed((DimW+2)'(px_s2));
  assign ys         = $signed((DimW+2)'(py_s2));
  assign gx1        = $signed((DimW+2)'(geom.x1));
  assign gx2        = $signed((DimW+2)'(geom.x2));
  assign gx3        = $signed((DimW+2)'(geom.x3));
  assign gy1        = $signed((DimW+2)'(geom.y1));
  assign gy2        = $signed((DimW+2)'(geom.y2));
  assign left_edge  = gx2 - $signed((DimW+2)'(lw_s2));
  assign right_edge = gx2 + $signed((DimW+2)'(lw_s2));
  assign in_span    = (xs >= left_edge) && (xs < right_edge);

  assign dx[0] = abs_diff(xs - gx1);
  assign dy[0] = abs_diff(gy1 - ys);
  assign dx[1] = abs_diff(xs - gx2);
  assign dy[1] = abs_diff(ys - gy2);
  assign dx[2] = abs_diff(gx3 - xs);
  assign dy[2] = abs_diff(gy1 - ys);

  always_ff @(posedge clk) begin
    ins_s3 <= iny_s2 && in_span;
    ins_s4 <= ins_s3;
    ins_s5 <= ins_s4;
  end

  // Stages three to five per channel: deltas, squares and their sum.
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    always_ff @(posedge clk) begin
      dx_s3[c]  <= dx[c];
      dy_s3[c]  <= dy[c];
      sqx_s4[c] <= SqW'(dx_s3[c]) * SqW'(dx_s3[c]);
      sqy_s4[c] <= SqW'(dy_s3[c]) * SqW'(dy_s3[c]);
      sum_s5[c] <= sqx_s4[c] + sqy_s4[c];
    end

    // Square root chain, most significant root bit first.
    assign sv[c][0] = sum_s5[c];
    assign sr[c][0] = '0;
    for (genvar i = 0; i < RootW; i++) begin : g_sqrt
      tgps_sqrt_cell #(.STEP(RootW - 1 - i)) u_cell (
        .clk   (clk),
        .v_in  (sv[c][i]),
        .r_in  (sr[c][i]),
        .v_out (sv[c][i+1]),
        .r_out (sr[c][i+1])
      );
    end
    assign root[c] = sr[c][RootW][RootW-1:0];

    // Dividend: remaining width scaled to the colour range, zero past the width.
    always_ff @(posedge clk) begin
      if (root[c] < geom.tw) begin
        dr[c][0] <= NumW'(geom.tw - root[c]) * NumW'(ColorOne);
      end else begin
        dr[c][0] <= '0;
      end
    end
    assign dq[c][0] = '0;

    // Divider chain by the triangle width, one quotient bit per cell.
    for (genvar j = 0; j < DivSteps; j++) begin : g_div
      tgps_div_cell #(.SHIFT(DivSteps - 1 - j)) u_cell (
        .clk     (clk),
        .den     (geom.tw),
        .rem_in  (dr[c][j]),
        .q_in    (dq[c][j]),
        .rem_out (dr[c][j+1]),
        .q_out   (dq[c][j+1])
      );
    end
  end

  // Control tags travelling beside the cell chains.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TagLen; i++) begin
        tag_line[i] <= '0;
      end
    end else begin
      tag_line[0] <= '{vld: v_s5, ins: ins_s5};
      for (int i = 1; i < TagLen; i++) begin
        tag_line[i] <= tag_line[i-1];
      end
    end
  end

  // Output register; pixels outside the triangle are black.
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done       <= tag_line[TagLen-1].vld;
      inside_res <= tag_line[TagLen-1].vld && tag_line[TagLen-1].ins;
    end
  end

  always_ff @(posedge clk) begin
    red   <= tag_line[TagLen-1].ins ? dq[0][DivSteps][ColW-1:0] : '0;
    green <= tag_line[TagLen-1].ins ? dq[1][DivSteps][ColW-1:0] : '0;
    blue  <= tag_line[TagLen-1].ins ? dq[2][DivSteps][ColW-1:0] : '0;
  end

  // Checks on the block's timing and control.
  `TGPS_ASSERT_DELAY(a_latency, start && !busy, Lat, done, "result not delivered on time")
  `TGPS_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready, busy, "no settle after a write")
  `TGPS_ASSERT_SAME(a_inside_done, inside_res, done, "inside flag without a result")

endmodule
